/* rtl/integer_to_ascii_padded_formatter_core_macros.svh */
// ----------------------------------------------------------------------------
// Integer formatter assertion macros
// Shared concurrent assertion forms used by the formatter RTL.
// ----------------------------------------------------------------------------
`ifndef INTEGER_TO_ASCII_PADDED_FORMATTER_CORE_MACROS_SVH
`define INTEGER_TO_ASCII_PADDED_FORMATTER_CORE_MACROS_SVH

// Antecedent in a cycle implies the consequent in the same cycle.
`define I2A_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Antecedent in a cycle implies the consequent in the following cycle.
`define I2A_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

// Condition holds at every clock edge out of reset.
`define I2A_ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");

`endif

/* rtl/i2a_pkg.sv */
// ----------------------------------------------------------------------------
// Integer formatter package
// Types, character codes and constants shared by the formatter modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package i2a_pkg;

    // Conversion modes.
    localparam logic [1:0] MODE_SDEC = 2'd0;
    localparam logic [1:0] MODE_UDEC = 2'd1;
    localparam logic [1:0] MODE_LHEX = 2'd2;
    localparam logic [1:0] MODE_UHEX = 2'd3;

    // Bit positions inside pad_mode.
    localparam int PAD_RIGHT_BIT = 0;
    localparam int PAD_ZERO_BIT  = 1;

    // ASCII codes.
    localparam logic [7:0] CHAR_MINUS   = 8'h2D;
    localparam logic [7:0] CHAR_SPACE   = 8'h20;
    localparam logic [7:0] CHAR_ZERO    = 8'h30;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;

    // Digit buffer and its index width.
    localparam int DIGIT_BUFFER_LEN = 12;
    localparam int BUF_IDX_W        = $clog2(DIGIT_BUFFER_LEN);

    // Most decimal digits a 32-bit magnitude can have.
    localparam logic [BUF_IDX_W-1:0] DEC_MAX_DIGITS = 4'd10;

    // Divide by ten as multiply by reciprocal: floor(x * 0xCCCCCCCD / 2^35).
    localparam logic [31:0] DEC_RECIP = 32'hCCCC_CCCD;
    localparam int          DEC_SHIFT = 35;
    localparam logic [3:0]  RADIX_DEC = 4'd10;

    // Classified item handed from the front to the back.
    typedef struct packed {
        logic [31:0] mag;
        logic        neg;
        logic        hex;
        logic        upper;
        logic        fill_right;
        logic        fill_zero;
    } item_t;

    // Back-end sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_PLAN,
        ST_SIGN,
        ST_LPAD,
        ST_MINUS,
        ST_DIGIT,
        ST_RPAD
    } state_t;

endpackage

`default_nettype wire

/* rtl/i2a_front.sv */
// ----------------------------------------------------------------------------
// Integer formatter front end
// Accepts input items, classifies them and hands them to the item queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module i2a_front #(
    parameter int MAX_WIDTH = 32,
    parameter int WW        = 6
) (
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [47:0]          s_tdata,   // value[31:0], mode, field_width, pad_mode
    output logic                      q_valid,
    input  wire logic                 q_ready,
    output i2a_pkg::item_t            q_item,
    output logic [WW-1:0]             q_width
);

    localparam logic [6:0] MAX_W7 = 7'(MAX_WIDTH);

    logic [31:0] value;
    logic [1:0]  mode;
    logic [5:0]  field_width;
    logic [1:0]  pad_mode;
    logic [6:0]  width_sat;

    // Unpack the payload fields.
    assign value       = s_tdata[31:0];
    assign mode        = s_tdata[33:32];
    assign field_width = s_tdata[39:34];
    assign pad_mode    = s_tdata[41:40];

    // Handshake passes straight through to the queue.
    assign q_valid  = s_tvalid;
    assign s_tready = q_ready;

    // Saturate the field width to the largest allowed width.
    assign width_sat = (7'(field_width) > MAX_W7) ? MAX_W7 : 7'(field_width);
    assign q_width   = width_sat[WW-1:0];

    // Classify: sign, magnitude, radix and letter case.
    always_comb
    begin
        q_item.neg        = (mode == i2a_pkg::MODE_SDEC) && value[31];
        q_item.mag        = q_item.neg ? (32'd0 - value) : value;
        q_item.hex        = (mode == i2a_pkg::MODE_LHEX) || (mode == i2a_pkg::MODE_UHEX);
        q_item.upper      = (mode == i2a_pkg::MODE_UHEX);
        q_item.fill_right = pad_mode[i2a_pkg::PAD_RIGHT_BIT];
        q_item.fill_zero  = pad_mode[i2a_pkg::PAD_ZERO_BIT];
    end

endmodule

`default_nettype wire

/* rtl/i2a_queue.sv */
// ----------------------------------------------------------------------------
// Integer formatter item queue
// Two-entry queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module i2a_queue #(
    parameter int DW = 44
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          wr_valid,
    output logic               wr_ready,
    input  wire logic [DW-1:0] wr_data,
    output logic               rd_valid,
    input  wire logic          rd_ready,
    output logic [DW-1:0]      rd_data
);

    logic [DW-1:0] mem_reg [2];
    logic          wr_ptr_reg, wr_ptr_next;
    logic          rd_ptr_reg, rd_ptr_next;
    logic [1:0]    cnt_reg, cnt_next;
    logic          push, pop;

    // Status and read port.
    assign wr_ready = (cnt_reg != 2'd2);
    assign rd_valid = (cnt_reg != 2'd0);
    assign rd_data  = mem_reg[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    // Pointer and fill count updates.
    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

/* rtl/i2a_back.sv */
// ----------------------------------------------------------------------------
// Integer formatter back end
// Converts a magnitude to digits one per cycle, then emits the padded field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "integer_to_ascii_padded_formatter_core_macros.svh"

module i2a_back #(
    parameter int WW        = 6
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            q_valid,
    output logic                 q_ready,
    input  wire i2a_pkg::item_t  q_item,
    input  wire logic [WW-1:0]   q_width,
    output logic                 m_tvalid,
    input  wire logic            m_tready,
    output logic [7:0]           m_tdata,   // char_out[7:0]
    output logic                 m_tlast    // last
);

    localparam int BW = i2a_pkg::BUF_IDX_W;

    i2a_pkg::state_t state_reg, state_next;

    // Item registers.
    logic [31:0]   mag_reg, mag_next;
    logic          neg_reg, neg_next;
    logic          hex_reg, hex_next;
    logic          upper_reg, upper_next;
    logic          right_reg, right_next;
    logic          zero_reg, zero_next;
    logic [WW-1:0] width_reg, width_next;

    // Digit buffer and sequencing counters.
    logic [7:0]    buf_reg [i2a_pkg::DIGIT_BUFFER_LEN];
    logic [BW-1:0] ndig_reg, ndig_next;
    logic [BW-1:0] idx_reg, idx_next;
    logic [WW-1:0] pad_cnt_reg, pad_cnt_next;
    logic [WW-1:0] rem_reg, rem_next;
    logic          inline_reg, inline_next;

    // Output register.
    logic          out_valid_reg, out_valid_next;
    logic [7:0]    char_reg, char_next;
    logic          last_reg, last_next;

    // Digit extraction datapath.
    logic [63:0]   prod;
    logic [31:0]   quot_dec, times10, rem_dec, quot;
    logic [3:0]    dval;
    logic [7:0]    dchar;
    logic          buf_wr;

    // Field plan.
    logic          lead_c, inline_c;
    logic [WW-1:0] w_eff, slen, padn, total;

    // Emission controls.
    logic          adv, emitting;
    logic [7:0]    emit_char;
    logic [7:0]    padch;

    // Terms used by the checks.
    logic          in_digit;
    logic          last_taken;

    assign adv      = !out_valid_reg || m_tready;
    assign q_ready  = (state_reg == i2a_pkg::ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = char_reg;
    assign m_tlast  = last_reg;

    // Divide by ten through the reciprocal, or take a nibble for hex.
    assign prod     = 64'(mag_reg) * 64'(i2a_pkg::DEC_RECIP);
    assign quot_dec = 32'(prod[63:i2a_pkg::DEC_SHIFT]);
    assign times10  = {quot_dec[28:0], 3'b000} + {quot_dec[30:0], 1'b0};
    assign rem_dec  = mag_reg - times10;
    assign quot     = hex_reg ? {4'h0, mag_reg[31:4]} : quot_dec;
    assign dval     = hex_reg ? mag_reg[3:0] : rem_dec[3:0];

    // Digit value to ASCII.
    always_comb
    begin
        if (dval < i2a_pkg::RADIX_DEC)
        begin
            dchar = i2a_pkg::CHAR_ZERO + 8'(dval);
        end
        else
        begin
            dchar = (upper_reg ? i2a_pkg::CHAR_UPPER_A : i2a_pkg::CHAR_LOWER_A)
                    + 8'(dval) - 8'(i2a_pkg::RADIX_DEC);
        end
    end

    // Work out the field layout once all digits are known.
    always_comb
    begin
        lead_c   = neg_reg && zero_reg && (width_reg != '0);
        inline_c = neg_reg && !lead_c;
        w_eff    = width_reg - WW'(lead_c);
        slen     = WW'(ndig_reg) + WW'(inline_c);
        padn     = (w_eff > slen) ? (w_eff - slen) : '0;
        total    = WW'(lead_c) + padn + slen;
    end

    assign padch = zero_reg ? i2a_pkg::CHAR_ZERO : i2a_pkg::CHAR_SPACE;

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            i2a_pkg::ST_IDLE:
            begin
                if (q_valid)
                    state_next = i2a_pkg::ST_CONV;
            end
            i2a_pkg::ST_CONV:
            begin
                if (quot == 32'd0)
                    state_next = i2a_pkg::ST_PLAN;
            end
            i2a_pkg::ST_PLAN:
            begin
                if (lead_c)
                    state_next = i2a_pkg::ST_SIGN;
                else if ((padn != '0) && !right_reg)
                    state_next = i2a_pkg::ST_LPAD;
                else if (inline_c)
                    state_next = i2a_pkg::ST_MINUS;
                else
                    state_next = i2a_pkg::ST_DIGIT;
            end
            i2a_pkg::ST_SIGN:
            begin
                if (adv)
                    state_next = ((pad_cnt_reg != '0) && !right_reg) ?
                                 i2a_pkg::ST_LPAD : i2a_pkg::ST_DIGIT;
            end
            i2a_pkg::ST_LPAD:
            begin
                if (adv && (pad_cnt_reg == WW'(1)))
                    state_next = inline_reg ? i2a_pkg::ST_MINUS : i2a_pkg::ST_DIGIT;
            end
            i2a_pkg::ST_MINUS:
            begin
                if (adv)
                    state_next = i2a_pkg::ST_DIGIT;
            end
            i2a_pkg::ST_DIGIT:
            begin
                if (adv && (idx_reg == '0))
                    state_next = (pad_cnt_reg != '0) ? i2a_pkg::ST_RPAD : i2a_pkg::ST_IDLE;
            end
            i2a_pkg::ST_RPAD:
            begin
                if (adv && (pad_cnt_reg == WW'(1)))
                    state_next = i2a_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = i2a_pkg::ST_IDLE;
            end
        endcase
    end

    // Output and datapath logic.
    always_comb
    begin
        mag_next       = mag_reg;
        neg_next       = neg_reg;
        hex_next       = hex_reg;
        upper_next     = upper_reg;
        right_next     = right_reg;
        zero_next      = zero_reg;
        width_next     = width_reg;
        ndig_next      = ndig_reg;
        idx_next       = idx_reg;
        pad_cnt_next   = pad_cnt_reg;
        rem_next       = rem_reg;
        inline_next    = inline_reg;
        buf_wr         = 1'b0;
        emitting       = 1'b0;
        emit_char      = padch;

        unique case (state_reg)
            i2a_pkg::ST_IDLE:
            begin
                if (q_valid)
                begin
                    mag_next   = q_item.mag;
                    neg_next   = q_item.neg;
                    hex_next   = q_item.hex;
                    upper_next = q_item.upper;
                    right_next = q_item.fill_right;
                    zero_next  = q_item.fill_zero;
                    width_next = q_width;
                    ndig_next  = '0;
                end
            end
            i2a_pkg::ST_CONV:
            begin
                buf_wr    = 1'b1;
                mag_next  = quot;
                ndig_next = ndig_reg + BW'(1);
            end
            i2a_pkg::ST_PLAN:
            begin
                pad_cnt_next = padn;
                rem_next     = total;
                inline_next  = inline_c;
                idx_next     = ndig_reg - BW'(1);
            end
            i2a_pkg::ST_SIGN, i2a_pkg::ST_MINUS:
            begin
                emitting  = 1'b1;
                emit_char = i2a_pkg::CHAR_MINUS;
            end
            i2a_pkg::ST_LPAD, i2a_pkg::ST_RPAD:
            begin
                emitting  = 1'b1;
                emit_char = padch;
                if (adv)
                    pad_cnt_next = pad_cnt_reg - WW'(1);
            end
            i2a_pkg::ST_DIGIT:
            begin
                emitting  = 1'b1;
                emit_char = buf_reg[idx_reg];
                if (adv)
                    idx_next = idx_reg - BW'(1);
            end
            default:
            begin
                emitting = 1'b0;
            end
        endcase

        // Count down the characters still owed for this field.
        if (emitting && adv)
            rem_next = rem_reg - WW'(1);

        // Output register loads whenever it is empty or being drained.
        out_valid_next = out_valid_reg;
        char_next      = char_reg;
        last_next      = last_reg;
        if (adv)
        begin
            out_valid_next = emitting;
            char_next      = emit_char;
            last_next      = (rem_reg == WW'(1));
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= i2a_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
            ndig_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            ndig_reg      <= ndig_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        mag_reg     <= mag_next;
        neg_reg     <= neg_next;
        hex_reg     <= hex_next;
        upper_reg   <= upper_next;
        right_reg   <= right_next;
        zero_reg    <= zero_next;
        width_reg   <= width_next;
        idx_reg     <= idx_next;
        pad_cnt_reg <= pad_cnt_next;
        rem_reg     <= rem_next;
        inline_reg  <= inline_next;
        char_reg    <= char_next;
        last_reg    <= last_next;
        if (buf_wr)
            buf_reg[ndig_reg] <= dchar;
    end

    // The digit state and the final accepted character of a field.
    assign in_digit   = (state_reg == i2a_pkg::ST_DIGIT);
    assign last_taken = emitting && adv && (rem_reg == WW'(1));

    // Checks on the sequencer.
    `I2A_ASSERT_ALWAYS(a_ndig_bound, clk, rst_n, ndig_reg <= i2a_pkg::DEC_MAX_DIGITS)
    `I2A_ASSERT_IMPLIES(a_rem_nonzero, clk, rst_n, emitting, rem_reg != '0)
    `I2A_ASSERT_IMPLIES(a_idx_in_range, clk, rst_n, in_digit, idx_reg < ndig_reg)
    `I2A_ASSERT_NEXT(a_last_ends_field, clk, rst_n, last_taken, state_reg == i2a_pkg::ST_IDLE)

endmodule

`default_nettype wire

/* rtl/integer_to_ascii_padded_formatter_core.sv */
// Flow: an accepted item reaches the back end through a two-entry queue; there its digits
// (1 to 10 decimal, 1 to 8 hex) are converted, the field planned and each character presented.
// The back end takes a new item only after the last character of the field, its pace set by
// the single divide-by-ten step per cycle and the one-character output register.
// Reset: rst_n is asynchronous, active low; it empties the queue, idles the sequencer and
// drops m_tvalid. No clearing pass is needed.
// ----------------------------------------------------------------------------
// Integer to ASCII padded formatter
// Formats a 32-bit value as a padded decimal or hex field, one character per item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module integer_to_ascii_padded_formatter_core #(
    parameter int MAX_WIDTH = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,   // value[31:0], mode[33:32], field_width[39:34], pad_mode[41:40]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // char_out[7:0]
    output logic             m_tlast    // last
);

    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int IW = $bits(i2a_pkg::item_t);
    localparam int DW = IW + WW;

    logic            f_valid, f_ready;
    i2a_pkg::item_t  f_item;
    logic [WW-1:0]   f_width;
    logic            b_valid, b_ready;
    logic [DW-1:0]   b_data;
    i2a_pkg::item_t  b_item;
    logic [WW-1:0]   b_width;

    // Front end: accept and classify.
    i2a_front #(
        .MAX_WIDTH (MAX_WIDTH),
        .WW        (WW)
    ) u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_valid  (f_valid),
        .q_ready  (f_ready),
        .q_item   (f_item),
        .q_width  (f_width)
    );

    // Queue between the two halves.
    i2a_queue #(
        .DW (DW)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (f_valid),
        .wr_ready (f_ready),
        .wr_data  ({f_width, f_item}),
        .rd_valid (b_valid),
        .rd_ready (b_ready),
        .rd_data  (b_data)
    );

    assign b_item  = i2a_pkg::item_t'(b_data[IW-1:0]);
    assign b_width = b_data[DW-1:IW];

    // Back end: digit conversion and field emission.
    i2a_back #(
        .WW        (WW)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (b_valid),
        .q_ready  (b_ready),
        .q_item   (b_item),
        .q_width  (b_width),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire

/* test/integer_to_ascii_padded_formatter_core_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Integer to ASCII padded formatter testbench
// Sends formatted-integer requests through the input stream and checks
// every output character against a predicted field. Coverage includes
// zero, sign placement, narrow and saturated widths, receiver hold-off
// and bursty random traffic.
// ----------------------------------------------------------------------------

module integer_to_ascii_padded_formatter_core_tb;

    localparam int MAX_WIDTH    = 32;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int HOLD_CYCLES  = 600;
    localparam int DRAIN_SETTLE = 60;

    // Pad selections, written as {zero, right}.
    localparam logic [1:0] PAD_LEFT_SPACE  = 2'b00;
    localparam logic [1:0] PAD_RIGHT_SPACE = 2'b01;
    localparam logic [1:0] PAD_LEFT_ZERO   = 2'b10;
    localparam logic [1:0] PAD_RIGHT_ZERO  = 2'b11;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } fmt_char_t;

    typedef enum int {
        RX_STEADY,
        RX_LIGHT,
        RX_HEAVY,
        RX_PATTERN
    } rx_style_t;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata  = '0;   // value[31:0], mode[33:32], field_width[39:34], pad_mode[41:40]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;         // char_out[7:0]
    logic        m_tlast;

    fmt_char_t   expected_chars[$];
    fmt_char_t   oldest_char;
    int          error_count   = 0;
    int          cycle_count   = 0;
    int          burst_left    = 0;
    bit          pacing_on     = 1'b1;
    int          hold_requests = 0;

    // Receiver-local state.
    int          hold_served = 0;
    int          hold_left   = 0;
    int          seg_left    = 0;
    rx_style_t   rx_style    = RX_STEADY;
    logic [7:0]  rx_mask     = 8'hFF;

    integer_to_ascii_padded_formatter_core #(
        .MAX_WIDTH(MAX_WIDTH)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // Free-running clock.
    always #2 clk = ~clk;

    // Build the character sequence of one formatted field and queue it.
    function automatic void predict_field_chars(logic [31:0] value, logic [1:0] mode,
                                                logic [5:0] field_width, logic [1:0] pad);
        logic [7:0]  digits[$];
        logic [7:0]  field[$];
        logic [31:0] mag;
        logic [7:0]  letter;
        logic [7:0]  pad_char;
        int unsigned base;
        int unsigned digit;
        int unsigned width;
        int unsigned fill;
        logic        neg;
        logic        zero_fill;
        logic        right_fill;
        fmt_char_t   entry;

        width      = (field_width > MAX_WIDTH) ? MAX_WIDTH : field_width;
        base       = (mode >= i2a_pkg::MODE_LHEX) ? 16 : 10;
        letter     = (mode == i2a_pkg::MODE_UHEX) ? i2a_pkg::CHAR_UPPER_A
                                                  : i2a_pkg::CHAR_LOWER_A;
        zero_fill  = pad[i2a_pkg::PAD_ZERO_BIT];
        right_fill = pad[i2a_pkg::PAD_RIGHT_BIT];
        neg        = 1'b0;
        mag        = value;

        if (value == 32'd0)
        begin
            digits.push_back(i2a_pkg::CHAR_ZERO);
        end
        else
        begin
            if (mode == i2a_pkg::MODE_SDEC && value[31])
            begin
                neg = 1'b1;
                mag = 32'd0 - value;
            end
            while (mag != 32'd0)
            begin
                digit = mag % base;
                digits.push_front(8'(digit >= 10 ? letter + digit - 10
                                                 : i2a_pkg::CHAR_ZERO + digit));
                mag = mag / base;
            end
            // With zero padding the sign leads and the padding follows it.
            if (neg)
            begin
                if (width != 0 && zero_fill)
                begin
                    field.push_back(i2a_pkg::CHAR_MINUS);
                    width--;
                end
                else
                begin
                    digits.push_front(i2a_pkg::CHAR_MINUS);
                end
            end
        end

        fill     = (width > digits.size()) ? width - digits.size() : 0;
        pad_char = zero_fill ? i2a_pkg::CHAR_ZERO : i2a_pkg::CHAR_SPACE;
        if (!right_fill)
            repeat (fill) field.push_back(pad_char);
        foreach (digits[i])
            field.push_back(digits[i]);
        if (right_fill)
            repeat (fill) field.push_back(pad_char);

        foreach (field[i])
        begin
            entry.ch   = field[i];
            entry.last = (i == field.size() - 1);
            expected_chars.push_back(entry);
        end
    endfunction

    // Predict the field of every accepted input item.
    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
            predict_field_chars(s_tdata[31:0], s_tdata[33:32], s_tdata[39:34], s_tdata[41:40]);
    end

    // Compare every accepted output item with the oldest predicted character.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_chars.size() == 0)
            begin
                $error("unexpected character: char_out %h last %b", m_tdata, m_tlast);
                error_count++;
            end
            else
            begin
                oldest_char = expected_chars.pop_front();
                if (m_tdata !== oldest_char.ch)
                begin
                    $error("char_out: expected %h, actual %h", oldest_char.ch, m_tdata);
                    error_count++;
                end
                if (m_tlast !== oldest_char.last)
                begin
                    $error("last: expected %b, actual %b", oldest_char.last, m_tlast);
                    error_count++;
                end
            end
        end
    end

    // Receiver: segments of different stall styles, plus a long hold-off on request.
    always @(posedge clk)
    begin
        if (hold_requests != hold_served)
        begin
            hold_served = hold_requests;
            hold_left   = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else
        begin
            if (seg_left == 0)
            begin
                seg_left = $urandom_range(200, 20);
                rx_style = rx_style_t'($urandom_range(3, 0));
                rx_mask  = 8'($urandom) | 8'h01;
            end
            seg_left--;
            case (rx_style)
                RX_STEADY: m_tready <= 1'b1;
                RX_LIGHT:  m_tready <= ($urandom_range(3, 0) != 0);
                RX_HEAVY:  m_tready <= ($urandom_range(3, 0) == 0);
                default:
                begin
                    m_tready <= rx_mask[0];
                    rx_mask = {rx_mask[0], rx_mask[7:1]};
                end
            endcase
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Offer one item and wait until it is accepted; gaps fall between bursts.
    task automatic send_item(logic [31:0] value, logic [1:0] mode,
                             logic [5:0] field_width, logic [1:0] pad);
        int gap;

        if (pacing_on && burst_left <= 0)
        begin
            burst_left = $urandom_range(12, 1);
            gap = ($urandom_range(7, 0) == 0) ? $urandom_range(60, 10) : $urandom_range(5, 0);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_tdata  <= {6'd0, pad, field_width, mode, value};
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
    endtask

    // Stop sending and wait until every predicted character has arrived.
    task automatic drain_outputs();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (expected_chars.size() != 0) @(posedge clk);
        repeat (DRAIN_SETTLE) @(posedge clk);
    endtask

    // One random request, weighted toward short fields and interesting values.
    task automatic send_random_item();
        logic [31:0] value;
        logic [5:0]  field_width;
        int          pick;

        case ($urandom_range(9, 0))
            0:       value = 32'd0;
            1:       value = $urandom_range(9, 1);
            2:       value = $urandom_range(99999, 0);
            3:       value = 32'd0 - $urandom_range(99999, 1);
            4:
            begin
                pick = $urandom_range(3, 0);
                value = (pick == 0) ? 32'h8000_0000 : (pick == 1) ? 32'hFFFF_FFFF :
                        (pick == 2) ? 32'h7FFF_FFFF : 32'h0000_0001;
            end
            default: value = $urandom;
        endcase
        pick = $urandom_range(9, 0);
        if (pick < 7)
            field_width = 6'($urandom_range(12, 0));
        else if (pick < 9)
            field_width = 6'($urandom_range(32, 13));
        else
            field_width = 6'($urandom_range(63, 33));
        send_item(value, 2'($urandom_range(3, 0)), field_width, 2'($urandom_range(3, 0)));
    endtask

    // Zero and the end points of the value range, across all four modes.
    task automatic test_zero_and_extremes();
        send_item(32'h0000_0000, i2a_pkg::MODE_SDEC, 6'd0,  PAD_LEFT_SPACE);
        send_item(32'h0000_0000, i2a_pkg::MODE_UHEX, 6'd5,  PAD_LEFT_ZERO);
        send_item(32'h0000_0000, i2a_pkg::MODE_LHEX, 6'd4,  PAD_RIGHT_SPACE);
        send_item(32'h8000_0000, i2a_pkg::MODE_SDEC, 6'd0,  PAD_LEFT_SPACE);
        send_item(32'hFFFF_FFFF, i2a_pkg::MODE_UDEC, 6'd0,  PAD_LEFT_SPACE);
        send_item(32'hFFFF_FFFF, i2a_pkg::MODE_LHEX, 6'd10, PAD_RIGHT_SPACE);
        send_item(32'hDEAD_BEEF, i2a_pkg::MODE_UHEX, 6'd12, PAD_LEFT_ZERO);
        send_item(32'h7FFF_FFFF, i2a_pkg::MODE_SDEC, 6'd11, PAD_RIGHT_ZERO);
        drain_outputs();
    endtask

    // Where the minus sign lands relative to the padding.
    task automatic test_sign_placement();
        send_item(32'hFFFF_FFFF, i2a_pkg::MODE_SDEC, 6'd8,  PAD_LEFT_ZERO);
        send_item(32'hFFFF_FFD6, i2a_pkg::MODE_SDEC, 6'd6,  PAD_LEFT_SPACE);
        send_item(32'hFFFF_FFD6, i2a_pkg::MODE_SDEC, 6'd6,  PAD_RIGHT_ZERO);
        send_item(32'hFFFF_FFD6, i2a_pkg::MODE_SDEC, 6'd6,  PAD_RIGHT_SPACE);
        send_item(32'hFFFF_FFF9, i2a_pkg::MODE_SDEC, 6'd1,  PAD_LEFT_ZERO);
        send_item(32'hFFFF_FFFF, i2a_pkg::MODE_SDEC, 6'd32, PAD_LEFT_ZERO);
        send_item(32'hFFFF_FFFF, i2a_pkg::MODE_UDEC, 6'd12, PAD_LEFT_ZERO);
        drain_outputs();
    endtask

    // Widths at and below the string length, and widths that saturate.
    task automatic test_width_limits();
        send_item(32'hABCD_EF01, i2a_pkg::MODE_LHEX, 6'd3,  PAD_LEFT_SPACE);
        send_item(32'd9,         i2a_pkg::MODE_SDEC, 6'd1,  PAD_LEFT_ZERO);
        send_item(32'd12345,     i2a_pkg::MODE_UDEC, 6'd32, PAD_RIGHT_SPACE);
        send_item(32'd1,         i2a_pkg::MODE_SDEC, 6'd63, PAD_LEFT_ZERO);
        send_item(32'h7FFF_FFFF, i2a_pkg::MODE_SDEC, 6'd33, PAD_LEFT_SPACE);
        send_item(32'h8000_0000, i2a_pkg::MODE_UHEX, 6'd40, PAD_RIGHT_ZERO);
        send_item(32'h8000_0000, i2a_pkg::MODE_SDEC, 6'd48, PAD_LEFT_ZERO);
        drain_outputs();
    endtask

    // Receiver holds off while the sender keeps offering items back to back.
    task automatic test_receiver_hold();
        hold_requests <= hold_requests + 1;
        pacing_on = 1'b0;
        repeat (24) send_random_item();
        pacing_on = 1'b1;
        drain_outputs();
    endtask

    // Bursty random traffic, with a stretch of back-to-back items in the middle.
    task automatic test_random_traffic();
        repeat (100) send_random_item();
        drain_outputs();
        pacing_on = 1'b0;
        repeat (30) send_random_item();
        pacing_on = 1'b1;
        repeat (100) send_random_item();
        drain_outputs();
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        test_zero_and_extremes();
        test_sign_placement();
        test_width_limits();
        test_receiver_hold();
        test_random_traffic();

        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

/* sim.f */
+incdir+rtl
rtl/i2a_pkg.sv
rtl/i2a_front.sv
rtl/i2a_queue.sv
rtl/i2a_back.sv
rtl/integer_to_ascii_padded_formatter_core.sv
test/integer_to_ascii_padded_formatter_core_tb.sv
